>>> design/tst_pkg.sv
// tst_pkg: shared types and codes for the timer slot table.
// Used by tst_mem and timer_slot_table; no dependencies.
`default_nettype none

package tst_pkg;

    localparam int SLOTS_DEF   = 16;
    localparam int MAX_RESULTS = 16;
    localparam int NRES_W      = $clog2(MAX_RESULTS + 1);

    localparam int ID_W    = 16;
    localparam int DELAY_W = 32;

    // request actions
    localparam logic [1:0] ACT_SCHED = 2'd0;
    localparam logic [1:0] ACT_KILL  = 2'd1;
    localparam logic [1:0] ACT_TICK  = 2'd2;

    // result kinds
    localparam logic KIND_STATUS = 1'b0;
    localparam logic KIND_FIRE   = 1'b1;

    // status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_BAD_ID    = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;
    localparam logic [1:0] ST_NOT_FOUND = 2'd3;

    // one memory word per slot
    typedef struct packed {
        logic [ID_W-1:0]    id;
        logic [DELAY_W-1:0] delay;
        logic [DELAY_W-1:0] elapsed;
        logic               periodic;
    } t_slot;

    typedef struct packed {
        logic            kind;
        logic [1:0]      status;
        logic [ID_W-1:0] fired_id;
        logic            one_shot;
        logic            last;
    } t_result;

endpackage

`default_nettype wire

>>> design/tst_mem.sv
// tst_mem: slot memory, one write port and one read port, registered read.
// Depends on tst_pkg for the slot word type.
`default_nettype none

module tst_mem
    import tst_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEF,
    localparam int IDXW = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
    input  wire logic            i_clk,
    input  wire logic            i_we,
    input  wire logic [IDXW-1:0] i_waddr,
    input  wire t_slot           i_wdata,
    input  wire logic            i_re,
    input  wire logic [IDXW-1:0] i_raddr,
    output t_slot                o_rdata
);

    t_slot r_mem [SLOTS];
    t_slot r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read data holds while no read is issued
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

>>> design/timer_slot_table.sv
// timer_slot_table: table of software timers keyed by id (schedule, kill, tick).
// Depends on tst_pkg and tst_mem.
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+-------------------------------------
//   in      | to block  | i_in_valid / o_in_ready | action, timer_id, delay, periodic
//   out     | from block| o_out_valid / i_out_ready | kind, status, fired_id,
//           |           |                        | was_one_shot, last
//
// Sweep: every schedule, kill or tick request sweeps all SLOTS entries of the
//   slot memory, one entry per cycle through its single read port while the
//   sweep is not stalled; a schedule with zero delay adds a fire state after it.
// Reset: synchronous, active low; valid bits are cleared, the memory is
//   never cleared (an entry's data is only used while its valid bit is set).
// Stalls: the output register is held until taken; a tick sweep pauses when a
//   second fire needs to leave while the output is still occupied.
`default_nettype none

module timer_slot_table
    import tst_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    // request channel
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire logic [1:0]         i_action,
    input  wire logic [ID_W-1:0]    i_timer_id,
    input  wire logic [DELAY_W-1:0] i_delay,
    input  wire logic               i_periodic,
    // result channel
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output logic                    o_kind,
    output logic [1:0]              o_status,
    output logic [ID_W-1:0]         o_fired_id,
    output logic                    o_was_one_shot,
    output logic                    o_last
);

    localparam int IDXW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SWEEP,   // walk all slots, one memory read per cycle unless stalled
        S_FINISH,  // schedule/kill: apply and report status
        S_FIRE0,   // schedule with zero delay: immediate fire result
        S_TFLUSH   // tick: release the held fire as the last result
    } t_state;

    t_state              r_state;

    // latched request
    logic [1:0]          r_act;
    logic [ID_W-1:0]     r_id;
    logic [DELAY_W-1:0]  r_delay;
    logic                r_per;

    logic                r_valid [SLOTS];
    logic [IDXW-1:0]     r_ev_idx;     // slot whose read data is on o_rdata

    // search results for schedule/kill
    logic                r_m_vld;
    logic [IDXW-1:0]     r_m_idx;
    logic                r_f_vld;
    logic [IDXW-1:0]     r_f_idx;

    // one fire is held back so the final one can carry last
    logic                r_h_vld;
    logic [ID_W-1:0]     r_h_id;
    logic                r_h_one;
    logic [NRES_W-1:0]   r_nres;

    logic                r_o_vld;
    t_result             r_out;

    // memory ports
    logic                mem_we;
    logic [IDXW-1:0]     mem_waddr;
    t_slot               mem_wdata;
    logic                mem_re;
    logic [IDXW-1:0]     mem_raddr;
    t_slot               rd;

    // sweep datapath
    logic                ev_valid;
    logic [DELAY_W-1:0]  el_inc;
    logic                fire;
    logic                is_tick;
    logic                report;
    logic                out_free;
    logic                stall;
    logic                advance;
    logic                last_slot;

    // finish logic
    logic                sched_found;
    logic [IDXW-1:0]     sched_slot;
    logic                sched_ok;

    logic                push;
    t_result             n_out;

    tst_mem #(
        .SLOTS (SLOTS)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (rd)
    );

    assign out_free  = !r_o_vld || i_out_ready;
    assign is_tick   = (r_act == ACT_TICK);
    assign ev_valid  = r_valid[r_ev_idx];
    // elapsed count saturates at all ones
    assign el_inc    = (&rd.elapsed) ? rd.elapsed : rd.elapsed + DELAY_W'(1);
    assign fire      = ev_valid && (el_inc >= rd.delay);
    // fires past the result limit update state but are not reported
    assign report    = is_tick && fire && (r_nres < NRES_W'(MAX_RESULTS));
    assign stall     = report && r_h_vld && !out_free;
    assign advance   = (r_state == S_SWEEP) && !stall;
    assign last_slot = (r_ev_idx == IDXW'(SLOTS - 1));

    assign sched_found = r_m_vld || r_f_vld;
    assign sched_slot  = r_m_vld ? r_m_idx : r_f_idx;
    assign sched_ok    = (r_id != '0) && sched_found;

    // memory access: reads walk the slots, writes are tick updates or a schedule
    always_comb begin
        mem_re    = 1'b0;
        mem_raddr = '0;
        mem_we    = 1'b0;
        mem_waddr = r_ev_idx;
        mem_wdata = rd;
        if (r_state == S_IDLE) begin
            mem_re = i_in_valid;
        end else if (advance) begin
            mem_re    = !last_slot;
            mem_raddr = IDXW'(r_ev_idx + 1'b1);
            if (is_tick && ev_valid) begin
                mem_we            = 1'b1;
                mem_wdata.elapsed = fire ? '0 : el_inc;
            end
        end else if (r_state == S_FINISH && r_act == ACT_SCHED && sched_ok && out_free) begin
            mem_we             = 1'b1;
            mem_waddr          = sched_slot;
            mem_wdata.id       = r_id;
            mem_wdata.delay    = r_delay;
            mem_wdata.elapsed  = '0;
            mem_wdata.periodic = r_per;
        end
    end

    // next result into the output register
    always_comb begin
        push           = 1'b0;
        n_out.kind     = KIND_STATUS;
        n_out.status   = ST_OK;
        n_out.fired_id = '0;
        n_out.one_shot = 1'b0;
        n_out.last     = 1'b1;
        unique case (r_state)
            S_SWEEP: begin
                push           = advance && report && r_h_vld;
                n_out.kind     = KIND_FIRE;
                n_out.fired_id = r_h_id;
                n_out.one_shot = r_h_one;
                n_out.last     = 1'b0;
            end
            S_FINISH: begin
                push = out_free;
                if (r_id == '0) begin
                    n_out.status = ST_BAD_ID;
                end else if (r_act == ACT_SCHED) begin
                    n_out.status = sched_found ? ST_OK : ST_FULL;
                    n_out.last   = !(sched_found && (r_delay == '0));
                end else begin
                    n_out.status = r_m_vld ? ST_OK : ST_NOT_FOUND;
                end
            end
            S_FIRE0: begin
                push           = out_free;
                n_out.kind     = KIND_FIRE;
                n_out.fired_id = r_id;
            end
            S_TFLUSH: begin
                push           = out_free && r_h_vld;
                n_out.kind     = KIND_FIRE;
                n_out.fired_id = r_h_id;
                n_out.one_shot = r_h_one;
            end
            default: begin
                push = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_o_vld <= 1'b0;
            r_h_vld <= 1'b0;
            for (int k = 0; k < SLOTS; k++) begin
                r_valid[k] <= 1'b0;
            end
        end else begin
            if (push) begin
                r_o_vld <= 1'b1;
                r_out   <= n_out;
            end else if (i_out_ready) begin
                r_o_vld <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_act    <= i_action;
                        r_id     <= i_timer_id;
                        r_delay  <= i_delay;
                        r_per    <= i_periodic;
                        r_ev_idx <= '0;
                        r_m_vld  <= 1'b0;
                        r_f_vld  <= 1'b0;
                        r_h_vld  <= 1'b0;
                        r_nres   <= '0;
                        // an unknown action is taken and dropped
                        if (i_action == ACT_SCHED || i_action == ACT_KILL ||
                            i_action == ACT_TICK) begin
                            r_state <= S_SWEEP;
                        end
                    end
                end
                S_SWEEP: begin
                    if (advance) begin
                        if (is_tick) begin
                            if (fire && !rd.periodic) begin
                                r_valid[r_ev_idx] <= 1'b0;
                            end
                            if (report) begin
                                r_h_vld <= 1'b1;
                                r_h_id  <= rd.id;
                                r_h_one <= !rd.periodic;
                                r_nres  <= NRES_W'(r_nres + 1'b1);
                            end
                        end else begin
                            if (ev_valid && rd.id == r_id && !r_m_vld) begin
                                r_m_vld <= 1'b1;
                                r_m_idx <= r_ev_idx;
                            end
                            // lowest free slot
                            if (!ev_valid && !r_f_vld) begin
                                r_f_vld <= 1'b1;
                                r_f_idx <= r_ev_idx;
                            end
                        end
                        if (last_slot) begin
                            r_state <= is_tick ? S_TFLUSH : S_FINISH;
                        end else begin
                            r_ev_idx <= IDXW'(r_ev_idx + 1'b1);
                        end
                    end
                end
                S_FINISH: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                        if (r_id != '0) begin
                            if (r_act == ACT_SCHED) begin
                                if (sched_found) begin
                                    r_valid[sched_slot] <= 1'b1;
                                    if (r_delay == '0) begin
                                        r_state <= S_FIRE0;
                                    end
                                end
                            end else if (r_m_vld) begin
                                r_valid[r_m_idx] <= 1'b0;
                            end
                        end
                    end
                end
                S_FIRE0: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                S_TFLUSH: begin
                    if (!r_h_vld || out_free) begin
                        r_h_vld <= 1'b0;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_ready     = (r_state == S_IDLE);
    assign o_out_valid    = r_o_vld;
    assign o_kind         = r_out.kind;
    assign o_status       = r_out.status;
    assign o_fired_id     = r_out.fired_id;
    assign o_was_one_shot = r_out.one_shot;
    assign o_last         = r_out.last;

endmodule

`default_nettype wire

>>> tb/tb.sv
`timescale 1ns / 1ps
// tb: self-checking bench for timer_slot_table, driven over its request and result handshakes.
// Depends on tst_pkg and the timer_slot_table RTL; carries its own timer table for prediction.
module tb
    import tst_pkg::*;
();

    // action code the block must ignore (no result at all)
    localparam logic [1:0] ACT_NONE = 2'd3;

    localparam int TBL_SLOTS    = SLOTS_DEF;
    localparam int RANDOM_ITEMS = 270;
    localparam int CALM_ITEMS   = 60;     // tail of the random part with no idling
    localparam int LONG_HOLD    = 300;    // one long result-side hold-off
    localparam int TAIL_CYCLES  = 3 * TBL_SLOTS;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int PLAN_ROWS    = 21;

    // one line of the directed plan; reps > 1 repeats the request with id counting up
    typedef struct {
        logic [1:0]         act;
        logic [ID_W-1:0]    id;
        logic [DELAY_W-1:0] dly;
        logic               per;
        int                 reps;
        bit                 typed;   // expected status typed in below
        logic [1:0]         want;
    } t_plan_row;

    logic               i_clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic [1:0]         in_action = ACT_NONE;
    logic [ID_W-1:0]    in_id = '0;
    logic [DELAY_W-1:0] in_delay = '0;
    logic               in_periodic = 1'b0;
    logic               out_ready = 1'b0;

    logic               o_in_ready;
    logic               o_out_valid;
    logic               o_kind;
    logic [1:0]         o_status;
    logic [ID_W-1:0]    o_fired_id;
    logic               o_was_one_shot;
    logic               o_last;

    // bench copy of the timer table
    bit                 tbl_live   [TBL_SLOTS];
    logic [ID_W-1:0]    tbl_id     [TBL_SLOTS];
    logic [DELAY_W-1:0] tbl_limit  [TBL_SLOTS];
    logic [DELAY_W-1:0] tbl_count  [TBL_SLOTS];
    logic               tbl_repeat [TBL_SLOTS];

    t_result   step_results[$];           // results of the request just accepted
    t_result   pending_timer_results[$];  // results still owed by the block
    t_plan_row plan [PLAN_ROWS];

    int mismatches    = 0;
    int cycles        = 0;
    int burst_mode    = 1;     // 0: no idling, 1: light, 2: heavy
    bit long_hold_req = 1'b0;

    timer_slot_table uut (
        .i_clk          (i_clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .o_in_ready     (o_in_ready),
        .i_action       (in_action),
        .i_timer_id     (in_id),
        .i_delay        (in_delay),
        .i_periodic     (in_periodic),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (out_ready),
        .o_kind         (o_kind),
        .o_status       (o_status),
        .o_fired_id     (o_fired_id),
        .o_was_one_shot (o_was_one_shot),
        .o_last         (o_last)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    function automatic t_result make_result(input logic kind, input logic [1:0] status,
                                            input logic [ID_W-1:0] id, input logic one_shot);
        t_result r;
        r.kind     = kind;
        r.status   = status;
        r.fired_id = id;
        r.one_shot = one_shot;
        r.last     = 1'b0;
        return r;
    endfunction

    // append one result to the request being modeled
    function automatic void add_step(input t_result r);
        step_results.insert(step_results.size(), r);
    endfunction

    // append one result to those the block still owes
    function automatic void owe_result(input t_result r);
        pending_timer_results.insert(pending_timer_results.size(), r);
    endfunction

    // Runs one request through the bench table and leaves its results in step_results.
    task automatic apply_timer_request(input logic [1:0] act, input logic [ID_W-1:0] id,
                                       input logic [DELAY_W-1:0] dly, input logic per);
        int hit;
        bit gone;
        step_results.delete();
        if (act == ACT_SCHED || act == ACT_KILL) begin
            hit = -1;
            for (int s = 0; s < TBL_SLOTS; s++)
                if (hit < 0 && tbl_live[s] && tbl_id[s] == id) hit = s;
            if (id == '0) begin
                add_step(make_result(KIND_STATUS, ST_BAD_ID, '0, 1'b0));
            end else if (act == ACT_KILL) begin
                if (hit < 0) begin
                    add_step(make_result(KIND_STATUS, ST_NOT_FOUND, '0, 1'b0));
                end else begin
                    tbl_live[hit] = 1'b0;
                    add_step(make_result(KIND_STATUS, ST_OK, '0, 1'b0));
                end
            end else begin
                // new id takes the lowest free slot
                for (int s = 0; s < TBL_SLOTS; s++)
                    if (hit < 0 && !tbl_live[s]) hit = s;
                if (hit < 0) begin
                    add_step(make_result(KIND_STATUS, ST_FULL, '0, 1'b0));
                end else begin
                    tbl_live[hit]   = 1'b1;
                    tbl_id[hit]     = id;
                    tbl_limit[hit]  = dly;
                    tbl_count[hit]  = '0;
                    tbl_repeat[hit] = per;
                    add_step(make_result(KIND_STATUS, ST_OK, '0, 1'b0));
                    // zero delay fires right away, entry stays
                    if (dly == '0)
                        add_step(make_result(KIND_FIRE, ST_OK, id, 1'b0));
                end
            end
        end else if (act == ACT_TICK) begin
            for (int s = 0; s < TBL_SLOTS; s++) begin
                if (tbl_live[s]) begin
                    if (tbl_count[s] != '1) tbl_count[s] = tbl_count[s] + 1'b1;  // saturates
                    if (tbl_count[s] >= tbl_limit[s]) begin
                        gone = !tbl_repeat[s];
                        if (gone) tbl_live[s] = 1'b0;
                        else      tbl_count[s] = '0;
                        if (step_results.size() < MAX_RESULTS)
                            add_step(make_result(KIND_FIRE, ST_OK, tbl_id[s], gone));
                    end
                end
            end
        end
        if (step_results.size() > 0)
            step_results[step_results.size() - 1].last = 1'b1;
    endtask

    // Offers one request, waits for it to be taken, then books what it must produce.
    task automatic offer_request(input logic [1:0] act, input logic [ID_W-1:0] id,
                                 input logic [DELAY_W-1:0] dly, input logic per,
                                 input bit typed, input logic [1:0] want);
        int gap;
        if (burst_mode != 0 && $urandom_range(0, 9) < 2 * burst_mode) begin
            gap = $urandom_range(1, 5);
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid    <= 1'b1;
        in_action   <= act;
        in_id       <= id;
        in_delay    <= dly;
        in_periodic <= per;
        do @(posedge i_clk); while (!o_in_ready);
        apply_timer_request(act, id, dly, per);
        if (typed) begin
            // typed status replaces the computed one; table state still advances
            owe_result(make_result(KIND_STATUS, want, '0, 1'b0));
            pending_timer_results[pending_timer_results.size() - 1].last = 1'b1;
        end else begin
            foreach (step_results[k]) owe_result(step_results[k]);
        end
    endtask

    // Result side: random stalls in bursts, plus one long hold-off that lets the
    // block back up and stall the request side.
    initial begin
        int gap;
        forever begin
            @(posedge i_clk);
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
                out_ready <= 1'b1;
            end else if (burst_mode != 0 && $urandom_range(0, 9) < 2 * burst_mode) begin
                gap = $urandom_range(1, 5);
                out_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
                out_ready <= 1'b1;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    // Compare every taken result against the oldest one owed.
    always @(posedge i_clk) begin
        t_result want;
        if (rst_n && o_out_valid && out_ready) begin
            if (pending_timer_results.size() == 0) begin
                $error("unexpected result: kind %0d status %0d fired_id %0h",
                       o_kind, o_status, o_fired_id);
                mismatches++;
            end else begin
                want = pending_timer_results.pop_front();
                if (o_kind !== want.kind) begin
                    $error("kind: expected %0d, got %0d", want.kind, o_kind);
                    mismatches++;
                end
                if (o_status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, o_status);
                    mismatches++;
                end
                if (o_fired_id !== want.fired_id) begin
                    $error("fired_id: expected %0h, got %0h", want.fired_id, o_fired_id);
                    mismatches++;
                end
                if (o_was_one_shot !== want.one_shot) begin
                    $error("was_one_shot: expected %0d, got %0d", want.one_shot, o_was_one_shot);
                    mismatches++;
                end
                if (o_last !== want.last) begin
                    $error("last: expected %0d, got %0d", want.last, o_last);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog.
    initial begin
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("FAILURE");
        $finish;
    end

    initial begin
        int                 counted;
        int                 pick;
        logic [1:0]         act;
        logic [ID_W-1:0]    id;
        logic [DELAY_W-1:0] dly;

        foreach (tbl_live[s]) tbl_live[s] = 1'b0;

        plan = '{
            // empty table: lookups miss, zero id refused, odd action and quiet tick silent
            '{ACT_KILL,  16'd5,      32'd0,          1'b0, 1,  1'b1, ST_NOT_FOUND},
            '{ACT_SCHED, 16'd0,      32'd7,          1'b1, 1,  1'b1, ST_BAD_ID},
            '{ACT_KILL,  16'd0,      32'd0,          1'b0, 1,  1'b1, ST_BAD_ID},
            '{ACT_NONE,  16'd7,      32'd3,          1'b1, 1,  1'b0, ST_OK},
            '{ACT_TICK,  16'd0,      32'd0,          1'b0, 1,  1'b0, ST_OK},
            // extremes of id and delay
            '{ACT_SCHED, 16'hFFFF,   32'hFFFF_FFFF,  1'b1, 1,  1'b1, ST_OK},
            // zero delay: status then fire at once; then the periodic one fires on every tick
            '{ACT_SCHED, 16'd1,      32'd0,          1'b0, 1,  1'b0, ST_OK},
            '{ACT_SCHED, 16'd2,      32'd0,          1'b1, 1,  1'b0, ST_OK},
            '{ACT_SCHED, 16'd3,      32'd1,          1'b0, 1,  1'b0, ST_OK},
            '{ACT_SCHED, 16'd4,      32'd2,          1'b1, 1,  1'b0, ST_OK},
            '{ACT_TICK,  16'd0,      32'd0,          1'b0, 1,  1'b0, ST_OK},
            '{ACT_TICK,  16'd0,      32'd0,          1'b0, 1,  1'b0, ST_OK},
            // replace a live id, clearing its count
            '{ACT_SCHED, 16'd4,      32'd3,          1'b0, 1,  1'b0, ST_OK},
            '{ACT_KILL,  16'hFFFF,   32'd0,          1'b0, 1,  1'b1, ST_OK},
            '{ACT_KILL,  16'hFFFF,   32'd0,          1'b0, 1,  1'b1, ST_NOT_FOUND},
            // fill every free slot, then a new id is refused but a replace works
            '{ACT_SCHED, 16'd100,    32'd5,          1'b1, 14, 1'b1, ST_OK},
            '{ACT_SCHED, 16'd200,    32'd1,          1'b0, 1,  1'b1, ST_FULL},
            '{ACT_SCHED, 16'd2,      32'hAAAA_5555,  1'b0, 1,  1'b1, ST_OK},
            // run the full table until the periodic batch fires together
            '{ACT_TICK,  16'd0,      32'd0,          1'b0, 6,  1'b0, ST_OK},
            '{ACT_KILL,  16'd100,    32'd0,          1'b0, 14, 1'b1, ST_OK},
            '{ACT_SCHED, 16'h5A5A,   32'h5555_AAAA,  1'b1, 1,  1'b1, ST_OK}
        };

        repeat (4) @(posedge i_clk);
        rst_n <= 1'b1;

        // directed part
        foreach (plan[r])
            for (int k = 0; k < plan[r].reps; k++)
                offer_request(plan[r].act, plan[r].id + ID_W'(k), plan[r].dly, plan[r].per,
                              plan[r].typed, plan[r].want);

        // random part: ids mostly from a small pool so replaces, kills and a full
        // table keep happening; delays mostly short so ticks fire often
        long_hold_req = 1'b1;
        counted = 0;
        while (counted < RANDOM_ITEMS) begin
            if (counted >= RANDOM_ITEMS - CALM_ITEMS) burst_mode = 0;
            else if (counted % 40 == 0) burst_mode = $urandom_range(0, 2);

            pick = $urandom_range(0, 99);
            if (pick < 3)       act = ACT_NONE;
            else if (pick < 45) act = ACT_SCHED;
            else if (pick < 62) act = ACT_KILL;
            else                act = ACT_TICK;

            pick = $urandom_range(0, 39);
            if (pick == 0)
                id = '0;
            else if (pick == 1 || (act != ACT_SCHED && pick < 8))
                id = ID_W'($urandom_range(0, 65535));
            else
                id = ID_W'($urandom_range(1, 20));

            pick = $urandom_range(0, 19);
            if (pick == 0)      dly = '1;
            else if (pick < 3)  dly = $urandom();
            else if (pick < 8)  dly = DELAY_W'($urandom_range(5, 12));
            else                dly = DELAY_W'($urandom_range(0, 4));

            offer_request(act, id, dly, 1'($urandom_range(0, 1)), 1'b0, ST_OK);
            if (act != ACT_NONE) counted++;
        end
        in_valid <= 1'b0;

        while (pending_timer_results.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

>>> files.f
design/tst_pkg.sv
design/tst_mem.sv
design/timer_slot_table.sv
tb/tb.sv
